[sv/rti_pkg.sv]
// Shared types and constants for the ray/triangle intersection core.
// Used by every module of the block; depends on nothing.
package rti_pkg;

	typedef logic signed [31:0]  w32_t;   // Q16.16 coordinate
	typedef logic signed [32:0]  dif_t;   // difference of two coordinates
	typedef logic signed [66:0]  crs_t;   // cross product component
	typedef logic signed [103:0] dot_t;   // dot product, 48 fraction bits

	localparam int NumW = 104;            // width of dot_t
	localparam int QBits = 32;            // quotient bits resolved by the divider

	localparam logic [1:0] RegDirX = 2'd0;
	localparam logic [1:0] RegDirY = 2'd1;
	localparam logic [1:0] RegDirZ = 2'd2;

	localparam logic signed [31:0] DirXRst = 32'sd0;
	localparam logic signed [31:0] DirYRst = 32'sd0;
	localparam logic signed [31:0] DirZRst = 32'sd65536;
	localparam logic signed [33:0] OneQ    = 34'sd65536;

endpackage

[sv/rti_cross.sv]
// Front end: edge vectors, origin offset and the two cross products.
// Three pipeline stages; uses rti_pkg.
module rti_cross (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rti_pkg::w32_t      dir [3],
	input  rti_pkg::w32_t      v0 [3],
	input  rti_pkg::w32_t      v1 [3],
	input  rti_pkg::w32_t      v2 [3],
	input  rti_pkg::w32_t      org [3],
	output logic               out_valid,
	input  logic               out_ready,
	output rti_pkg::dif_t      dir_o [3],
	output rti_pkg::dif_t      e1_o [3],
	output rti_pkg::dif_t      e2_o [3],
	output rti_pkg::dif_t      s_o [3],
	output rti_pkg::crs_t      q_o [3],
	output rti_pkg::crs_t      r_o [3]
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	rti_pkg::dif_t dir_s1 [3], e1_s1 [3], e2_s1 [3], s_s1 [3];
	rti_pkg::dif_t dir_s2 [3], e1_s2 [3], e2_s2 [3], s_s2 [3];
	rti_pkg::dif_t dir_s3 [3], e1_s3 [3], e2_s3 [3], s_s3 [3];
	logic signed [65:0] qa_s2 [3], qb_s2 [3], ra_s2 [3], rb_s2 [3];
	rti_pkg::crs_t q_s3 [3], r_s3 [3];

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (rdy1 && in_valid) begin
				dir_s1[k] <= {dir[k][31], dir[k]};
				e1_s1[k]  <= {v1[k][31], v1[k]} - {v0[k][31], v0[k]};
				e2_s1[k]  <= {v2[k][31], v2[k]} - {v0[k][31], v0[k]};
				s_s1[k]   <= {org[k][31], org[k]} - {v0[k][31], v0[k]};
			end
			if (rdy2 && v_s1) begin
				qa_s2[k] <= dir_s1[(k + 1) % 3] * e2_s1[(k + 2) % 3];
				qb_s2[k] <= dir_s1[(k + 2) % 3] * e2_s1[(k + 1) % 3];
				ra_s2[k] <= s_s1[(k + 1) % 3] * e1_s1[(k + 2) % 3];
				rb_s2[k] <= s_s1[(k + 2) % 3] * e1_s1[(k + 1) % 3];
				dir_s2[k] <= dir_s1[k];
				e1_s2[k]  <= e1_s1[k];
				e2_s2[k]  <= e2_s1[k];
				s_s2[k]   <= s_s1[k];
			end
			if (rdy3 && v_s2) begin
				q_s3[k]   <= {qa_s2[k][65], qa_s2[k]} - {qb_s2[k][65], qb_s2[k]};
				r_s3[k]   <= {ra_s2[k][65], ra_s2[k]} - {rb_s2[k][65], rb_s2[k]};
				dir_s3[k] <= dir_s2[k];
				e1_s3[k]  <= e1_s2[k];
				e2_s3[k]  <= e2_s2[k];
				s_s3[k]   <= s_s2[k];
			end
		end
	end

	assign dir_o = dir_s3;
	assign e1_o  = e1_s3;
	assign e2_o  = e2_s3;
	assign s_o   = s_s3;
	assign q_o   = q_s3;
	assign r_o   = r_s3;

endmodule

[sv/rti_dot.sv]
// Three-term dot product of short by wide signed vectors, each product
// split into two partial products. Three stages; uses rti_pkg.
module rti_dot (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rti_pkg::dif_t  x [3],
	input  rti_pkg::crs_t  y [3],
	output logic           out_valid,
	input  logic           out_ready,
	output rti_pkg::dot_t  dot
);

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	logic signed [65:0] hi_s1 [3];
	logic signed [67:0] lo_s1 [3];
	logic [99:0] prod_s2 [3];
	rti_pkg::dot_t sum_s3;

	assign rdy3      = !v_s3 || out_ready;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign in_ready  = rdy1;
	assign out_valid = v_s3;
	assign dot       = sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (rdy1 && in_valid) begin
				// Upper slice is signed, lower 34 bits are taken as unsigned.
				hi_s1[k] <= x[k] * $signed(y[k][66:34]);
				lo_s1[k] <= x[k] * $signed({1'b0, y[k][33:0]});
			end
			if (rdy2 && v_s1) begin
				prod_s2[k] <= {hi_s1[k], 34'b0} + {{32{lo_s1[k][67]}}, lo_s1[k]};
			end
		end
		if (rdy3 && v_s2) begin
			sum_s3 <= $signed({{4{prod_s2[0][99]}}, prod_s2[0]})
				+ $signed({{4{prod_s2[1][99]}}, prod_s2[1]})
				+ $signed({{4{prod_s2[2][99]}}, prod_s2[2]});
		end
	end

endmodule

[sv/rti_div.sv]
// Pipelined restoring divider: (num * 2^16) / den, truncated toward zero,
// saturated to 32 bits signed, zero for a zero divisor. Uses rti_pkg.
module rti_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rti_pkg::dot_t  num,
	input  rti_pkg::dot_t  den,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    quo,
	output logic           den_pos
);

	localparam int Nw  = rti_pkg::NumW;
	localparam int Qb  = rti_pkg::QBits;
	localparam int Rw  = Nw + Qb;          // room for the divisor at its largest shift
	localparam int Nst = Qb + 2;           // prepare, one stage per bit, finish

	logic vld [Nst];
	logic rdy [Nst + 1];

	logic [Rw-1:0] rem_s [Qb + 1];
	logic [Nw-1:0] dm_s  [Qb + 1];
	logic [Qb-1:0] q_s   [Qb + 1];
	logic neg_s [Qb + 1], ovf_s [Qb + 1], zero_s [Qb + 1], dpos_s [Qb + 1];
	logic [31:0] quo_s34;
	logic dpos_s34;

	logic [Nw-1:0] nmag, dmag;

	assign rdy[Nst] = out_ready;
	for (genvar g = 0; g < Nst; g++) begin : g_rdy
		assign rdy[g] = !vld[g] || rdy[g + 1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Nst; k++) vld[k] <= 1'b0;
		end else begin
			if (rdy[0]) vld[0] <= in_valid;
			for (int k = 1; k < Nst; k++) begin
				if (rdy[k]) vld[k] <= vld[k - 1];
			end
		end
	end

	assign nmag = num[Nw-1] ? Nw'(-num) : Nw'(num);
	assign dmag = den[Nw-1] ? Nw'(-den) : Nw'(den);

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			rem_s[0]  <= {16'b0, nmag, 16'b0};
			dm_s[0]   <= dmag;
			q_s[0]    <= '0;
			// The quotient reaches 2^32 exactly when |num| >= |den| * 2^16.
			ovf_s[0]  <= {16'b0, nmag} >= {dmag, 16'b0};
			zero_s[0] <= (den == '0);
			neg_s[0]  <= num[Nw-1] ^ den[Nw-1];
			dpos_s[0] <= !den[Nw-1] && (den != '0);
		end
	end

	for (genvar j = 0; j < Qb; j++) begin : g_step
		logic [Rw-1:0] dsh;
		logic          ge;
		assign dsh = {{Qb{1'b0}}, dm_s[j]} << (Qb - 1 - j);
		assign ge  = rem_s[j] >= dsh;
		always_ff @(posedge clk) begin
			if (rdy[j + 1] && vld[j]) begin
				rem_s[j + 1]  <= ge ? rem_s[j] - dsh : rem_s[j];
				q_s[j + 1]    <= {q_s[j][Qb-2:0], ge};
				dm_s[j + 1]   <= dm_s[j];
				ovf_s[j + 1]  <= ovf_s[j];
				zero_s[j + 1] <= zero_s[j];
				neg_s[j + 1]  <= neg_s[j];
				dpos_s[j + 1] <= dpos_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[Nst - 1] && vld[Nst - 2]) begin
			dpos_s34 <= dpos_s[Qb];
			if (zero_s[Qb]) begin
				quo_s34 <= '0;
			end else if (neg_s[Qb]) begin
				if (ovf_s[Qb] || q_s[Qb] > 32'h8000_0000) quo_s34 <= 32'h8000_0000;
				else quo_s34 <= 32'(-q_s[Qb]);
			end else begin
				if (ovf_s[Qb] || q_s[Qb] > 32'h7FFF_FFFF) quo_s34 <= 32'h7FFF_FFFF;
				else quo_s34 <= q_s[Qb];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld[Nst - 1];
	assign quo       = quo_s34;
	assign den_pos   = dpos_s34;

endmodule

[sv/ray_triangle_intersection_core.sv]
// Top level of the ray/triangle intersection core (front-face test).
// Depends on rti_pkg, rti_cross, rti_dot and rti_div.
//
// The core takes one triangle and one ray origin per input word and returns
// one result word per triangle: a hit flag, the barycentric weights u and v
// and the distance t along the ray, all signed Q16.16. The ray direction is
// held in three registers written over the configuration channel (index 0,
// 1 and 2 for x, y and z; reset value (0, 0, 1.0)); write them only while
// no triangle is in flight. The core is fully pipelined: it accepts a new
// word in every cycle while the output is not stalled. A word passes
// through three stages for the cross products, three for the dot products,
// 34 for the divider (one stage per quotient bit plus set-up and a sign and
// saturation stage) and the output register. Each stage holds its word while
// the stage after it is full, so back-pressure on the output never loses or
// repeats a result, and empty stages keep filling while the output waits. A
// zero determinant gives zero weights and distance; otherwise the quotients
// saturate to range.
module ray_triangle_intersection_core (
	input  logic         clk,
	input  logic         arst_n,
	// tdata, lowest bit up: vert0_x, vert0_y, vert0_z, vert1_x, vert1_y,
	// vert1_z, vert2_x, vert2_y, vert2_z, origin_x, origin_y, origin_z
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [383:0] s_tdata,
	// tdata, lowest bit up: hit, bary_u, bary_v, distance, 7 zero bits
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	rti_pkg::w32_t dir_q [3];
	rti_pkg::w32_t v0 [3], v1 [3], v2 [3], org [3];

	// Configuration is always taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q[0] <= rti_pkg::DirXRst;
			dir_q[1] <= rti_pkg::DirYRst;
			dir_q[2] <= rti_pkg::DirZRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				rti_pkg::RegDirX: dir_q[0] <= cfg_data;
				rti_pkg::RegDirY: dir_q[1] <= cfg_data;
				rti_pkg::RegDirZ: dir_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_unpack
		assign v0[k]  = s_tdata[32*k      +: 32];
		assign v1[k]  = s_tdata[32*(k+3)  +: 32];
		assign v2[k]  = s_tdata[32*(k+6)  +: 32];
		assign org[k] = s_tdata[32*(k+9)  +: 32];
	end

	// Cross products.
	logic cr_valid, cr_ready;
	rti_pkg::dif_t dir_c [3], e1_c [3], e2_c [3], s_c [3];
	rti_pkg::crs_t q_c [3], r_c [3];

	rti_cross u_cross (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.dir(dir_q), .v0(v0), .v1(v1), .v2(v2), .org(org),
		.out_valid(cr_valid), .out_ready(cr_ready),
		.dir_o(dir_c), .e1_o(e1_c), .e2_o(e2_c), .s_o(s_c), .q_o(q_c), .r_o(r_c)
	);

	// Determinant and the three numerators run side by side in lock step.
	logic [3:0] dt_in_rdy, dt_out_vld;
	logic dt_valid, dt_ready;
	rti_pkg::dot_t det, num_u, num_v, num_t;

	rti_dot u_dot_det (
		.clk(clk), .arst_n(arst_n), .in_valid(cr_valid), .in_ready(dt_in_rdy[0]),
		.x(e1_c), .y(q_c), .out_valid(dt_out_vld[0]), .out_ready(dt_ready), .dot(det)
	);
	rti_dot u_dot_u (
		.clk(clk), .arst_n(arst_n), .in_valid(cr_valid), .in_ready(dt_in_rdy[1]),
		.x(s_c), .y(q_c), .out_valid(dt_out_vld[1]), .out_ready(dt_ready), .dot(num_u)
	);
	rti_dot u_dot_v (
		.clk(clk), .arst_n(arst_n), .in_valid(cr_valid), .in_ready(dt_in_rdy[2]),
		.x(dir_c), .y(r_c), .out_valid(dt_out_vld[2]), .out_ready(dt_ready), .dot(num_v)
	);
	rti_dot u_dot_t (
		.clk(clk), .arst_n(arst_n), .in_valid(cr_valid), .in_ready(dt_in_rdy[3]),
		.x(e2_c), .y(r_c), .out_valid(dt_out_vld[3]), .out_ready(dt_ready), .dot(num_t)
	);

	assign cr_ready = &dt_in_rdy;
	assign dt_valid = &dt_out_vld;

	// Three dividers share the determinant.
	logic [2:0] dv_in_rdy, dv_out_vld, dv_pos;
	logic dv_valid, dv_ready;
	logic [31:0] quo_u, quo_v, quo_t;

	rti_div u_div_u (
		.clk(clk), .arst_n(arst_n), .in_valid(dt_valid), .in_ready(dv_in_rdy[0]),
		.num(num_u), .den(det), .out_valid(dv_out_vld[0]), .out_ready(dv_ready),
		.quo(quo_u), .den_pos(dv_pos[0])
	);
	rti_div u_div_v (
		.clk(clk), .arst_n(arst_n), .in_valid(dt_valid), .in_ready(dv_in_rdy[1]),
		.num(num_v), .den(det), .out_valid(dv_out_vld[1]), .out_ready(dv_ready),
		.quo(quo_v), .den_pos(dv_pos[1])
	);
	rti_div u_div_t (
		.clk(clk), .arst_n(arst_n), .in_valid(dt_valid), .in_ready(dv_in_rdy[2]),
		.num(num_t), .den(det), .out_valid(dv_out_vld[2]), .out_ready(dv_ready),
		.quo(quo_t), .den_pos(dv_pos[2])
	);

	assign dt_ready = &dv_in_rdy;
	assign dv_valid = &dv_out_vld;

	// Hit test on the saturated quotients, then the output register.
	logic signed [33:0] rest;
	logic hit;
	logic out_vld_q;
	logic [103:0] out_data_q;

	assign rest = rti_pkg::OneQ - {{2{quo_u[31]}}, quo_u} - {{2{quo_v[31]}}, quo_v};
	assign hit  = (&dv_pos) && !quo_u[31] && !quo_v[31] && !rest[33]
		&& !quo_t[31] && (quo_t != '0);

	assign dv_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (dv_ready) begin
			out_vld_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready && dv_valid) begin
			out_data_q <= {7'b0, quo_t, quo_v, quo_u, hit};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// A reported hit always carries non-negative weights and a positive distance.
	a_hit_u : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[32])
		else $error("hit reported with negative u");
	a_hit_v : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[64])
		else $error("hit reported with negative v");
	a_hit_t : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[96] && (m_tdata[96:65] != 32'd0))
		else $error("hit reported with non-positive distance");
	a_lockstep : assert property (@(posedge clk) disable iff (!arst_n)
		(dt_out_vld == 4'b0000 || dt_out_vld == 4'b1111)
		&& (dv_out_vld == 3'b000 || dv_out_vld == 3'b111))
		else $error("parallel units out of step");

endmodule
